// File: hw/rtl/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_HOLDS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed");
`else
`define ASSERT_HOLDS(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif
`endif

// File: hw/rtl/drp_pkg.sv
`timescale 1ns / 1ps
package drp_pkg;
    localparam int FRAC_BITS     = 16;
    localparam int MIN_DISPARITY = 10;
    localparam int MAX_COLUMNS   = 2048;
    localparam int MAX_ROWS      = 2048;
    localparam int COORD_W       = 32;
    localparam int PROD_W        = 46;
    localparam int NUM_REGS      = 8;
    localparam int CFG_IDX_W     = 4;
    localparam int CFG_W         = 64;
    localparam int MAC_STAGES    = 2;
    localparam int DIV_STAGES    = COORD_W + 3;
    localparam int COL_W         = 11;
    localparam int ROW_W         = 11;
    localparam int DISP_W        = 8;
    localparam int COLOR_W       = 24;

    typedef logic signed [COORD_W-1:0] entry_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    typedef struct packed {
        logic [COORD_W-1:0] value;
        logic               sat;
    } div_res_t;
endpackage

// File: hw/rtl/drp_mac.sv
`timescale 1ns / 1ps
module drp_mac (
    input  logic                   clk,
    input  logic                   en,
    input  logic [10:0]            col,
    input  logic [10:0]            row,
    input  logic [7:0]             disp,
    input  drp_pkg::entry_t        q_mat [0:3][0:3],
    output drp_pkg::prod_t         sums  [0:3]
);
    import drp_pkg::*;

    localparam int MUL_W = COORD_W + COL_W + 1;

    logic signed [MUL_W-1:0] pc_reg [0:3];
    logic signed [MUL_W-1:0] pr_reg [0:3];
    logic signed [MUL_W-1:0] pd_reg [0:3];
    entry_t                  k_reg  [0:3];
    prod_t                   sum_reg [0:3];

    for (genvar r = 0; r < 4; r++) begin : g_row
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pc_reg[r]  <= q_mat[r][0] * $signed({1'b0, col});
                pr_reg[r]  <= q_mat[r][1] * $signed({1'b0, row});
                pd_reg[r]  <= MUL_W'(q_mat[r][2] * $signed({1'b0, disp}));
                k_reg[r]   <= q_mat[r][3];
                sum_reg[r] <= PROD_W'(pc_reg[r]) + PROD_W'(pr_reg[r])
                            + PROD_W'(pd_reg[r]) + PROD_W'(k_reg[r]);
            end
        end
        assign sums[r] = sum_reg[r];
    end
endmodule

// File: hw/rtl/drp_div.sv
`timescale 1ns / 1ps
module drp_div #(
    parameter int FRACTION_BITS = drp_pkg::FRAC_BITS
) (
    input  logic              clk,
    input  logic              en,
    input  drp_pkg::prod_t    num,
    input  drp_pkg::prod_t    den,
    output drp_pkg::div_res_t res
);
    import drp_pkg::*;

    localparam int DW = PROD_W + COORD_W;

    logic              neg_a_reg;
    logic [PROD_W-1:0] an_a_reg;
    logic [PROD_W-1:0] ad_a_reg;

    logic [DW-1:0]      rem_reg [0:31];
    logic [PROD_W-1:0]  den_reg [0:31];
    logic [COORD_W-1:0] quo_reg [0:32];
    logic               neg_reg [0:32];
    logic               ovf_reg [0:32];

    div_res_t res_reg;
    div_res_t res_next;

    // sign split
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_a_reg <= num[PROD_W-1] ^ den[PROD_W-1];
            an_a_reg  <= num[PROD_W-1] ? PROD_W'(-num) : PROD_W'(num);
            ad_a_reg  <= den[PROD_W-1] ? PROD_W'(-den) : PROD_W'(den);
        end
    end

    // quotient of 2^32 or more saturates
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg[0] <= neg_a_reg;
            ovf_reg[0] <= (DW'(an_a_reg) << FRACTION_BITS) >= (DW'(ad_a_reg) << COORD_W);
            rem_reg[0] <= DW'(an_a_reg) << FRACTION_BITS;
            den_reg[0] <= ad_a_reg;
            quo_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < COORD_W; k++) begin : g_bit
        localparam int B = COORD_W - 1 - k;
        logic [DW-1:0] trial;
        logic          ge;

        assign trial = DW'(den_reg[k]) << B;
        assign ge    = rem_reg[k] >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[k+1] <= quo_reg[k] | (COORD_W'(ge) << B);
                neg_reg[k+1] <= neg_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end

        if (k < COORD_W - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k+1] <= ge ? rem_reg[k] - trial : rem_reg[k];
                    den_reg[k+1] <= den_reg[k];
                end
            end
        end
    end

    always_comb
    begin
        logic [COORD_W:0] limit;
        logic [COORD_W-1:0] q;
        q     = quo_reg[COORD_W];
        limit = neg_reg[COORD_W] ? {1'b0, 1'b1, {(COORD_W-1){1'b0}}}
                                 : {2'b00, {(COORD_W-1){1'b1}}};
        res_next.sat = ovf_reg[COORD_W] || ({1'b0, q} > limit);
        if (res_next.sat)
            res_next.value = neg_reg[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}}
                                              : {1'b0, {(COORD_W-1){1'b1}}};
        else
            res_next.value = neg_reg[COORD_W] ? (~q + COORD_W'(1)) : q;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    assign res = res_reg;
endmodule

// File: hw/rtl/disparity_to_point_reprojection.sv
`timescale 1ns / 1ps
// channel   dir  tdata (lowest bit up)                               tuser
// s_axis    in   pixel_col, pixel_row, disparity, red, green, blue    -
// m_axis    out  point_x, point_y, point_z, packed_color              range_fault
// cfg       in   cfg_we, cfg_index, cfg_data (64-bit matrix pair)
//
// one pixel per clock while the skid entry is empty; m_axis_tvalid rises once a pixel
// clears input, MAC, divider, output registers; one quotient bit per stage, three lanes
// pixels with low disparity or outside the image are dropped at the input stage
// rst_n clears valid bits and matrix registers; a 2-entry output skid holds results
// s_axis_tready drops only while the skid entry is full
module disparity_to_point_reprojection #(
    parameter int FRACTION_BITS = drp_pkg::FRAC_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [55:0]                    s_axis_tdata,  // col, row, disparity, r, g, b
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [119:0]                   m_axis_tdata,  // x, y, z, packed color
    output logic                           m_axis_tuser,  // range_fault
    input  logic                           cfg_we,
    input  logic [drp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [drp_pkg::CFG_W-1:0]      cfg_data
);
    import drp_pkg::*;
    `include "assert_macros.svh"

    localparam int LAST = MAC_STAGES + DIV_STAGES;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               zero;
    } meta_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [COLOR_W-1:0] color;
        logic               fault;
    } word_t;

    logic [CFG_W-1:0] cfg_reg [0:NUM_REGS-1];
    entry_t           q_mat   [0:3][0:3];

    logic             en;
    logic             accept;
    logic             pass;
    logic             v_reg [0:LAST];
    meta_t            m_reg [0:LAST];
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [DISP_W-1:0] disp_reg;
    prod_t            sums [0:3];
    div_res_t         res  [0:2];

    word_t            pipe_word;
    word_t            out_reg;
    word_t            skid_reg;
    logic             out_valid_reg;
    logic             skid_valid_reg;
    logic             load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
                cfg_reg[i] <= '0;
        end
        else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_REGS)))
        begin
            cfg_reg[cfg_index[$clog2(NUM_REGS)-1:0]] <= cfg_data;
        end
    end

    for (genvar r = 0; r < 4; r++) begin : g_qr
        for (genvar c = 0; c < 4; c++) begin : g_qc
            if (c % 2 == 0) begin : g_hi
                assign q_mat[r][c] = cfg_reg[r*2 + c/2][CFG_W-1:COORD_W];
            end
            else begin : g_lo
                assign q_mat[r][c] = cfg_reg[r*2 + c/2][COORD_W-1:0];
            end
        end
    end

    assign en            = !skid_valid_reg;
    assign s_axis_tready = en;
    assign accept        = s_axis_tvalid && en;
    assign pass = (s_axis_tdata[29:22] >= DISP_W'(MIN_DISPARITY))
               && ({3'b000, s_axis_tdata[10:0]} < 14'(MAX_COLUMNS))
               && ({3'b000, s_axis_tdata[21:11]} < 14'(MAX_ROWS));

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= LAST; i++)
                v_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= accept && pass;
            for (int i = 1; i <= LAST; i++)
                v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            col_reg        <= s_axis_tdata[10:0];
            row_reg        <= s_axis_tdata[21:11];
            disp_reg       <= s_axis_tdata[29:22];
            m_reg[0].color <= {s_axis_tdata[37:30], s_axis_tdata[45:38], s_axis_tdata[53:46]};
            m_reg[0].zero  <= 1'b0;
            for (int i = 1; i <= LAST; i++)
                if (i != MAC_STAGES + 1)
                    m_reg[i] <= m_reg[i-1];
            m_reg[MAC_STAGES+1].color <= m_reg[MAC_STAGES].color;
            m_reg[MAC_STAGES+1].zero  <= (sums[3] == '0);
        end
    end

    drp_mac u_mac (
        .clk   (clk),
        .en    (en),
        .col   (col_reg),
        .row   (row_reg),
        .disp  (disp_reg),
        .q_mat (q_mat),
        .sums  (sums)
    );

    for (genvar l = 0; l < 3; l++) begin : g_lane
        drp_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
            .clk (clk),
            .en  (en),
            .num (sums[l]),
            .den (sums[3]),
            .res (res[l])
        );
    end

    always_comb
    begin
        pipe_word.x     = m_reg[LAST].zero ? '0 : res[0].value;
        pipe_word.y     = m_reg[LAST].zero ? '0 : res[1].value;
        pipe_word.z     = m_reg[LAST].zero ? '0 : res[2].value;
        pipe_word.color = m_reg[LAST].color;
        pipe_word.fault = m_reg[LAST].zero || res[0].sat || res[1].sat || res[2].sat;
    end

    assign load = en && v_reg[LAST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && !m_axis_tready)
        begin
            if (load)
                skid_valid_reg <= 1'b1;
        end
        else if (skid_valid_reg)
        begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_valid_reg && !m_axis_tready)
        begin
            if (load)
                skid_reg <= pipe_word;
        end
        else if (skid_valid_reg)
            out_reg <= skid_reg;
        else if (load)
            out_reg <= pipe_word;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.color, out_reg.z, out_reg.y, out_reg.x};
    assign m_axis_tuser  = out_reg.fault;

    `ASSERT_HOLDS(a_skid_behind_out, clk, rst_n, !skid_valid_reg || out_valid_reg)
    `ASSERT_NEXT(a_skid_holds, clk, rst_n, skid_valid_reg && !m_axis_tready, skid_valid_reg)
    `ASSERT_NEXT(a_skid_fills, clk, rst_n, out_valid_reg && !m_axis_tready && load, skid_valid_reg)
endmodule

// File: tb/disparity_to_point_reprojection_tb.sv
`timescale 1ns / 1ps
module disparity_to_point_reprojection_tb;
    import drp_pkg::*;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW0_01, REG_ROW0_23, REG_ROW1_01, REG_ROW1_23,
        REG_ROW2_01, REG_ROW2_23, REG_ROW3_01, REG_ROW3_23
    } reg_idx_e;

    typedef enum int {
        MAT_CAMERA, MAT_ALL_MAX, MAT_ALL_MIN, MAT_RANDOM,
        MAT_TINY_W, MAT_CAMERA_NOISE, MAT_ZERO_W, MAT_RANDOM_B
    } mat_kind_e;

    typedef struct packed {
        logic [10:0] col;
        logic [10:0] row;
        logic [7:0]  disp;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } pixel_t;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [23:0] color;
        logic        fault;
    } point_t;

    typedef struct packed {
        logic   by_eye;
        logic   has_point;
        point_t pt;
    } tag_t;

    typedef struct packed {
        pixel_t px;
        tag_t   tag;
    } dir_row_t;

    localparam int DIR_SPLIT = 5;
    localparam int DIR_ROWS  = 9;
    localparam int LATENCY   = 39;
    localparam int STALL_LIM = 5000;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           s_axis_tvalid = 1'b0;
    logic           s_axis_tready;
    logic [55:0]    s_axis_tdata = '0;
    logic           m_axis_tvalid;
    logic           m_axis_tready = 1'b0;
    logic [119:0]   m_axis_tdata;
    logic           m_axis_tuser;
    logic           cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    logic [63:0] q_mat [NUM_REGS];
    tag_t        tag_q [$];
    point_t      point_q [$];
    int          idle_mode = 0;
    int          errors = 0;
    int          pixels_in = 0;
    int          points_out = 0;
    int          faults_out = 0;
    int          quiet_cycles = 0;

    dir_row_t dir_tab [DIR_ROWS] = '{
        '{'{11'd0, 11'd0, 8'd9, 8'h00, 8'h00, 8'h00}, '{1'b1, 1'b0, '0}},
        '{'{11'd0, 11'd0, 8'd0, 8'hff, 8'hff, 8'hff}, '{1'b1, 1'b0, '0}},
        '{'{11'd0, 11'd0, 8'd10, 8'h00, 8'h00, 8'h00},
          '{1'b1, 1'b1, '{32'd0, 32'd0, 32'd0, 24'h000000, 1'b1}}},
        '{'{11'd2047, 11'd2047, 8'd255, 8'hff, 8'hff, 8'hff},
          '{1'b1, 1'b1, '{32'd0, 32'd0, 32'd0, 24'hffffff, 1'b1}}},
        '{'{11'd1024, 11'd5, 8'd128, 8'h12, 8'h34, 8'h56},
          '{1'b1, 1'b1, '{32'd0, 32'd0, 32'd0, 24'h123456, 1'b1}}},
        '{'{11'd0, 11'd0, 8'd10, 8'haa, 8'h55, 8'haa}, '{1'b0, 1'b0, '0}},
        '{'{11'd2047, 11'd2047, 8'd255, 8'h55, 8'haa, 8'h55}, '{1'b0, 1'b0, '0}},
        '{'{11'd320, 11'd240, 8'd64, 8'h01, 8'h80, 8'hfe}, '{1'b0, 1'b0, '0}},
        '{'{11'd2047, 11'd0, 8'd9, 8'h7f, 8'h00, 8'h80}, '{1'b0, 1'b0, '0}}
    };

    disparity_to_point_reprojection dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic longint q_entry(int r, int c);
        logic [63:0] w;
        logic [31:0] e;
        w = q_mat[r * 2 + c / 2];
        e = (c % 2 == 0) ? w[63:32] : w[31:0];
        return longint'($signed(e));
    endfunction

    function automatic logic [31:0] fixed_quotient(longint num, longint den, inout logic sat);
        logic        neg;
        longint unsigned an;
        longint unsigned ad;
        longint unsigned q;
        longint unsigned lim;
        neg = (num < 0) != (den < 0);
        an = (num < 0) ? longint'(-num) : num;
        ad = (den < 0) ? longint'(-den) : den;
        lim = neg ? 64'h8000_0000 : 64'h7fff_ffff;
        q = (an << FRAC_BITS) / ad;
        if (q > lim)
        begin
            sat = 1'b1;
            return neg ? 32'h8000_0000 : 32'h7fff_ffff;
        end
        return neg ? -q[31:0] : q[31:0];
    endfunction

    function automatic logic project_pixel(pixel_t p, output point_t pt);
        longint prod [4];
        logic   sat;
        sat = 1'b0;
        pt = '0;
        if (p.disp < MIN_DISPARITY || p.col >= MAX_COLUMNS || p.row >= MAX_ROWS)
            return 1'b0;
        for (int r = 0; r < 4; r++)
            prod[r] = q_entry(r, 0) * longint'(p.col) + q_entry(r, 1) * longint'(p.row)
                    + q_entry(r, 2) * longint'(p.disp) + q_entry(r, 3);
        if (prod[3] == 0)
            sat = 1'b1;
        else
        begin
            pt.x = fixed_quotient(prod[0], prod[3], sat);
            pt.y = fixed_quotient(prod[1], prod[3], sat);
            pt.z = fixed_quotient(prod[2], prod[3], sat);
        end
        pt.color = {p.red, p.green, p.blue};
        pt.fault = sat;
        return 1'b1;
    endfunction

    always @(posedge clk)
    begin
        tag_t   tg;
        point_t pt;
        point_t got;
        logic   has;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            pixels_in++;
            tg = tag_q.pop_front();
            has = project_pixel(pixel_t'({s_axis_tdata[10:0], s_axis_tdata[21:11],
                s_axis_tdata[29:22], s_axis_tdata[37:30], s_axis_tdata[45:38],
                s_axis_tdata[53:46]}), pt);
            if (tg.by_eye)
            begin
                has = tg.has_point;
                pt = tg.pt;
            end
            if (has)
                point_q = {point_q, pt};
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            points_out++;
            got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
                   m_axis_tdata[119:96], m_axis_tuser};
            faults_out += got.fault;
            if (point_q.size() == 0)
            begin
                $error("unexpected word: %h", got);
                errors++;
            end
            else
            begin
                pt = point_q.pop_front();
                if (got.x !== pt.x)
                begin
                    $error("point_x expected %h actual %h", pt.x, got.x);
                    errors++;
                end
                if (got.y !== pt.y)
                begin
                    $error("point_y expected %h actual %h", pt.y, got.y);
                    errors++;
                end
                if (got.z !== pt.z)
                begin
                    $error("point_z expected %h actual %h", pt.z, got.z);
                    errors++;
                end
                if (got.color !== pt.color)
                begin
                    $error("packed_color expected %h actual %h", pt.color, got.color);
                    errors++;
                end
                if (got.fault !== pt.fault)
                begin
                    $error("range_fault expected %b actual %b", pt.fault, got.fault);
                    errors++;
                end
            end
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIM)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(negedge clk)
        m_axis_tready <= (idle_mode == 2) ? ($urandom_range(99) >= 62) :
                         (idle_mode == 3) ? ($urandom_range(99) >= 34) : 1'b1;

    function automatic logic sender_idles();
        if (idle_mode == 1)
            return $urandom_range(99) < 62;
        if (idle_mode == 3)
            return $urandom_range(99) < 34;
        return 1'b0;
    endfunction

    // caller sits at a falling edge
    task automatic send_pixel(pixel_t p, tag_t tg);
        while (sender_idles())
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        tag_q = {tag_q, tg};
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, p.blue, p.green, p.red, p.disp, p.row, p.col};
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (point_q.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 20) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx < NUM_REGS)
            q_mat[idx] = val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] fx(int v);
        return v << FRAC_BITS;
    endfunction

    task automatic load_matrix(mat_kind_e kind);
        logic [31:0] e [16];
        for (int i = 0; i < 16; i++)
            e[i] = $urandom();
        case (kind)
            MAT_CAMERA, MAT_CAMERA_NOISE:
            begin
                e = '{fx(1), 0, 0, fx(-320), 0, fx(1), 0, fx(-240),
                      0, 0, 0, fx(500), 0, 0, 32'd8192, 0};
                if (kind == MAT_CAMERA_NOISE)
                    for (int i = 0; i < 16; i++)
                        e[i] += $urandom_range(255) - 128;
            end
            MAT_ALL_MAX:
                for (int i = 0; i < 16; i++)
                    e[i] = 32'h7fff_ffff;
            MAT_ALL_MIN:
                for (int i = 0; i < 16; i++)
                    e[i] = 32'h8000_0000;
            MAT_TINY_W:
                for (int i = 12; i < 16; i++)
                    e[i] = $urandom_range(3);
            MAT_ZERO_W:
                for (int i = 12; i < 16; i++)
                    e[i] = 0;
            default: ;
        endcase
        write_reg(REG_ROW0_01, {e[0], e[1]});
        write_reg(REG_ROW0_23, {e[2], e[3]});
        write_reg(REG_ROW1_01, {e[4], e[5]});
        write_reg(REG_ROW1_23, {e[6], e[7]});
        write_reg(REG_ROW2_01, {e[8], e[9]});
        write_reg(REG_ROW2_23, {e[10], e[11]});
        write_reg(REG_ROW3_01, {e[12], e[13]});
        write_reg(REG_ROW3_23, {e[14], e[15]});
        // unmapped index must not disturb the matrix
        write_reg(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, NUM_REGS)),
                  {$urandom(), $urandom()});
    endtask

    function automatic pixel_t random_pixel();
        pixel_t p;
        p = pixel_t'(54'({$urandom(), $urandom()}));
        case ($urandom_range(19))
            0, 1: p.disp = 8'($urandom_range(MIN_DISPARITY - 1));
            2:    p.disp = 8'(MIN_DISPARITY);
            3:    p.disp = 8'hff;
            default: p.disp = 8'($urandom_range(255, MIN_DISPARITY));
        endcase
        return p;
    endfunction

    initial
    begin
        for (int i = 0; i < NUM_REGS; i++)
            q_mat[i] = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int k = 0; k < DIR_ROWS; k++)
        begin
            if (k == DIR_SPLIT)
            begin
                drain();
                load_matrix(MAT_CAMERA);
            end
            send_pixel(dir_tab[k].px, dir_tab[k].tag);
        end

        for (int ph = 0; ph < 8; ph++)
        begin
            drain();
            idle_mode = ph % 4;
            load_matrix(mat_kind_e'(ph));
            for (int n = 0; n < 130; n++)
            begin
                if (ph == 2 && n == 65)
                begin
                    s_axis_tvalid <= 1'b0;
                    while (point_q.size() != 0)
                        @(negedge clk);
                    @(negedge clk);
                end
                send_pixel(random_pixel(), '0);
            end
        end

        s_axis_tvalid <= 1'b0;
        idle_mode = 0;
        while (point_q.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 20) @(negedge clk);
        $display("%0d pixels in, %0d points out (%0d flagged), over 10 matrix settings",
                 pixels_in, points_out, faults_out);
        $display("idle patterns: none, sender gaps, receiver stalls, both");
        if (errors == 0 && point_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
